FILE: hdl/sroe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the shift register output expander.
// Used by shift_register_output_expander_unit and its testbench; depends on nothing else.
package sroe_pkg;

  // Number of pins held in the shadow and enable stores.
  localparam int MAX_PINS = 32;
  localparam int PIN_W    = (MAX_PINS > 1) ? $clog2(MAX_PINS) : 1;
  localparam int CNT_W    = $clog2(MAX_PINS + 1);

  // Fixed field widths of the interface.
  localparam int MODE_W   = 2;
  localparam int PINIDX_W = 6;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 6;
  localparam int CFGIDX_W = 1;

  // Access kinds; the fourth code is undefined.
  typedef enum logic [MODE_W-1:0] {
    MODE_CFG   = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  // Pin functions for a configure access.
  typedef enum logic [FUNC_W-1:0] {
    FN_RELEASE = 2'd0,
    FN_OUTPUT  = 2'd1,
    FN_KEEP    = 2'd2,
    FN_INPUT   = 2'd3
  } func_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_BOUNDS      = 3'd1,
    ST_UNSUP       = 3'd2,
    ST_NOT_ENABLED = 3'd3,
    ST_INVALID_FN  = 3'd4
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CFGIDX_W-1:0] {
    CFG_OUT_COUNT = 1'b0,
    CFG_REVERSE   = 1'b1
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic {
    S_IDLE  = 1'b0,
    S_SHIFT = 1'b1
  } state_e;

  localparam logic [CFG_W-1:0] OUT_COUNT_RESET = 6'd8;

endpackage

FILE: hdl/shift_register_output_expander_unit.sv
`timescale 1ns / 1ps
// Top level of the shift register output expander: access decode, shadow
// and enable stores, the chain shift register and the result register.
// Depends on sroe_pkg.
//
// Usage: an access (configure, write or read of one pin) is transferred on
// the input channel when in_valid_i is high and in_stall_o is low. Results
// leave on the output channel when out_valid_o is high and out_stall_i low.
// An access that does not drive the chain gives one result, registered in
// the cycle after the transfer; such accesses can follow each other every
// cycle while the output is not stalled. A write, or a release, copies the
// shadow levels into a shift register and sends one result per chain bit,
// one bit per cycle while the output is not stalled, the final one marked
// by last_o (the latch pulse). The chain length is the output count, capped
// at the store size; the next access is transferred at the edge where the
// last bit leaves. During a shift run the input is stalled. A stall at the
// output holds the current result and freezes the shift run. Reset clears
// all pins to level zero and not enabled, sets the output count to 8 and
// reverse order off. Configuration is written through cfg_we_i, cfg_index_i
// and cfg_wdata_i while idle.
module shift_register_output_expander_unit
  import sroe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CFGIDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  // Access channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [PINIDX_W-1:0] pin_index_i,
  input  logic [FUNC_W-1:0]   function_code_i,
  input  logic                push_pull_i,
  input  logic                write_value_i,
  // Result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic                read_value_o,
  output logic                shift_bit_o,
  output logic                shift_valid_o,
  output logic                last_o
);

  // Configuration registers.
  logic [CFG_W-1:0] out_count_q;
  logic             reverse_q;

  // Pin stores.
  logic [MAX_PINS-1:0] shadow_q, shadow_d;
  logic [MAX_PINS-1:0] enabled_q, enabled_d;

  // Shift run state.
  state_e              state_q, state_d;
  logic [MAX_PINS-1:0] sr_q, sr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  status_e             run_status_q, run_status_d;

  // Result register.
  logic                out_valid_q, out_valid_d;
  status_e             status_q, status_d;
  logic                rd_q, rd_d;
  logic                bit_q, bit_d;
  logic                sv_q, sv_d;
  logic                last_q, last_d;

  // Decode signals.
  logic             accept;
  logic             out_free;
  logic [CNT_W-1:0] chain_len;
  logic [PIN_W-1:0] pidx;
  logic             in_bounds;
  logic             dec_shift;
  status_e          dec_status;
  logic             dec_rd;
  logic [MAX_PINS-1:0] load_vec;

  // The result register is free when empty or when its result leaves now.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_count_q <= OUT_COUNT_RESET;
      reverse_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_OUT_COUNT: out_count_q <= cfg_wdata_i;
        CFG_REVERSE:   reverse_q   <= cfg_wdata_i[0];
      endcase
    end
  end

  // Chain length is the output count capped at the store size.
  always_comb begin
    if (int'(out_count_q) > MAX_PINS) begin
      chain_len = CNT_W'(MAX_PINS);
    end else begin
      chain_len = CNT_W'(out_count_q);
    end
  end

  assign pidx      = pin_index_i[PIN_W-1:0];
  assign in_bounds = (int'(pin_index_i) < int'(out_count_q)) &&
                     (int'(pin_index_i) < MAX_PINS);

  // Access decode and store updates.
  always_comb begin
    shadow_d   = shadow_q;
    enabled_d  = enabled_q;
    dec_shift  = 1'b0;
    dec_status = ST_OK;
    dec_rd     = 1'b0;
    unique case (mode_e'(mode_i))
      MODE_CFG: begin
        if (!in_bounds) begin
          dec_status = ST_BOUNDS;
        end else begin
          unique case (func_e'(function_code_i))
            FN_INPUT: dec_status = ST_UNSUP;
            FN_RELEASE: begin
              shadow_d[pidx]  = 1'b0;
              enabled_d[pidx] = 1'b0;
              dec_shift       = 1'b1;
              dec_status      = push_pull_i ? ST_OK : ST_UNSUP;
            end
            FN_OUTPUT, FN_KEEP: begin
              if (push_pull_i) begin
                enabled_d[pidx] = 1'b1;
              end else begin
                dec_status = ST_UNSUP;
              end
            end
          endcase
        end
      end
      MODE_WRITE: begin
        if (!in_bounds) begin
          dec_status = ST_BOUNDS;
        end else if (!enabled_q[pidx]) begin
          dec_status = ST_NOT_ENABLED;
        end else begin
          shadow_d[pidx] = write_value_i;
          dec_shift      = 1'b1;
        end
      end
      MODE_READ: begin
        if (!in_bounds) begin
          dec_status = ST_BOUNDS;
        end else if (!enabled_q[pidx]) begin
          dec_status = ST_NOT_ENABLED;
        end else begin
          dec_rd = shadow_q[pidx];
        end
      end
      default: dec_status = ST_UNSUP;
    endcase
  end

  // In reverse order the highest chain pin is aligned to the top bit.
  always_comb begin
    if (reverse_q) begin
      load_vec = shadow_d << (CNT_W'(MAX_PINS) - chain_len);
    end else begin
      load_vec = shadow_d;
    end
  end

  // Sequencer: next state, shift register and result register.
  always_comb begin
    state_d      = state_q;
    sr_d         = sr_q;
    cnt_d        = cnt_q;
    run_status_d = run_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    rd_d         = rd_q;
    bit_d        = bit_q;
    sv_d         = sv_q;
    last_d       = last_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (dec_shift) begin
            sr_d         = load_vec;
            cnt_d        = chain_len;
            run_status_d = dec_status;
            state_d      = S_SHIFT;
          end else begin
            out_valid_d = 1'b1;
            status_d    = dec_status;
            rd_d        = dec_rd;
            bit_d       = 1'b0;
            sv_d        = 1'b0;
            last_d      = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = run_status_q;
          rd_d        = 1'b0;
          sv_d        = 1'b1;
          last_d      = (cnt_q == CNT_W'(1));
          if (reverse_q) begin
            bit_d = sr_q[MAX_PINS-1];
            sr_d  = sr_q << 1;
          end else begin
            bit_d = sr_q[0];
            sr_d  = sr_q >> 1;
          end
          cnt_d = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and store registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      shadow_q    <= '0;
      enabled_q   <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (accept) begin
        shadow_q  <= shadow_d;
        enabled_q <= enabled_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sr_q         <= sr_d;
    run_status_q <= run_status_d;
    status_q     <= status_d;
    rd_q         <= rd_d;
    bit_q        <= bit_d;
    sv_q         <= sv_d;
    last_q       <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_value_o  = rd_q;
  assign shift_bit_o   = bit_q;
  assign shift_valid_o = sv_q;
  assign last_o        = last_q;

`ifndef SYNTHESIS
  // A shift run never sits with an empty bit count.
  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHIFT |-> cnt_q != '0)
    else $error("shift run with zero remaining bits");

  // A result that carries no chain pulse always closes its access.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !sv_q |-> last_q)
    else $error("non-shift result without last");

  // Chain results never report a read level.
  a_shift_no_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && sv_q |-> !rd_q)
    else $error("read level on a chain result");

  // A shifting access starts a run on the next cycle.
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && dec_shift |=> state_q == S_SHIFT && !out_valid_q ||
      state_q == S_SHIFT && out_valid_q && sv_q)
    else $error("shifting access did not start a run");

  // The final chain bit returns the sequencer to idle with last set.
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHIFT && out_free && cnt_q == CNT_W'(1) |=>
      state_q == S_IDLE && out_valid_q && last_q)
    else $error("shift run did not end on its last bit");
`endif

endmodule

FILE: tb/shift_register_output_expander_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for shift_register_output_expander_unit.
// Predicts every result of each pin access and compares it on the result
// channel; depends on sroe_pkg and the unit itself.
module shift_register_output_expander_unit_tb
  import sroe_pkg::*;
();

  // The fourth access kind has no enum member in the package.
  localparam logic [MODE_W-1:0] MODE_UNDEFINED = 2'd3;
  localparam int LONG_HOLD      = 250;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int END_CYCLES     = 40;

  typedef struct {
    logic [MODE_W-1:0]   mode;
    logic [PINIDX_W-1:0] pin;
    func_e               fn;
    logic                push_pull;
    logic                level;
  } pin_access_t;

  typedef struct {
    status_e status;
    logic    read_value;
    logic    shift_bit;
    logic    shift_valid;
    logic    last;
  } chain_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CFGIDX_W-1:0] cfg_index_i = CFG_OUT_COUNT;
  logic [CFG_W-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [MODE_W-1:0]   mode_i = MODE_READ;
  logic [PINIDX_W-1:0] pin_index_i = '0;
  logic [FUNC_W-1:0]   function_code_i = FN_OUTPUT;
  logic                push_pull_i = 1'b0;
  logic                write_value_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic                read_value_o;
  logic                shift_bit_o;
  logic                shift_valid_o;
  logic                last_o;

  shift_register_output_expander_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .pin_index_i     (pin_index_i),
    .function_code_i (function_code_i),
    .push_pull_i     (push_pull_i),
    .write_value_i   (write_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .read_value_o    (read_value_o),
    .shift_bit_o     (shift_bit_o),
    .shift_valid_o   (shift_valid_o),
    .last_o          (last_o)
  );

  // Pending accesses for the driver and predicted results for the checker.
  pin_access_t   pin_accesses[$];
  chain_result_t predicted_results[$];

  // Shadow copy of the expander state and its settings.
  logic [MAX_PINS-1:0] pin_levels;
  logic [MAX_PINS-1:0] pin_on;
  logic [CFG_W-1:0]    chain_pins;
  logic                chain_reversed;

  // Idling controls; an odds value of zero turns idling off.
  int unsigned sender_odds = 4;
  int unsigned receiver_odds = 4;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned hold_cycles = 0;
  bit          in_xfer = 1'b0;

  int unsigned quiet_cycles = 0;
  int unsigned n_accesses = 0;
  int unsigned n_results = 0;
  int unsigned n_chain_bits = 0;
  int unsigned n_settings = 0;
  int unsigned n_errors = 0;

  // Clock with a 2 ns period.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  task automatic push_single(input status_e st, input logic rd);
    predicted_results.push_back('{st, rd, 1'b0, 1'b0, 1'b1});
  endtask

  // A shifting access sends the whole chain, capped at the store size.
  task automatic push_chain(input status_e st);
    int len;
    int src;
    len = (chain_pins > MAX_PINS) ? MAX_PINS : int'(chain_pins);
    for (int i = 0; i < len; i++) begin
      src = chain_reversed ? (len - 1 - i) : i;
      predicted_results.push_back('{st, 1'b0, pin_levels[src], 1'b1, i == len - 1});
    end
  endtask

  // Works out the results of one transferred access and updates the state.
  task automatic predict_access(input pin_access_t a);
    if (a.mode != MODE_CFG && a.mode != MODE_WRITE && a.mode != MODE_READ) begin
      push_single(ST_UNSUP, 1'b0);
    end else if (a.pin >= chain_pins || a.pin >= MAX_PINS) begin
      push_single(ST_BOUNDS, 1'b0);
    end else begin
      case (a.mode)
        MODE_CFG: begin
          case (a.fn)
            FN_INPUT: begin
              push_single(ST_UNSUP, 1'b0);
            end
            FN_RELEASE: begin
              // A release clears the pin and shifts, but never enables it.
              pin_on[a.pin] = 1'b0;
              pin_levels[a.pin] = 1'b0;
              push_chain(a.push_pull ? ST_OK : ST_UNSUP);
            end
            default: begin
              if (!a.push_pull) begin
                push_single(ST_UNSUP, 1'b0);
              end else begin
                pin_on[a.pin] = 1'b1;
                push_single(ST_OK, 1'b0);
              end
            end
          endcase
        end
        MODE_WRITE: begin
          if (!pin_on[a.pin]) begin
            push_single(ST_NOT_ENABLED, 1'b0);
          end else begin
            pin_levels[a.pin] = a.level;
            push_chain(ST_OK);
          end
        end
        default: begin
          if (!pin_on[a.pin]) begin
            push_single(ST_NOT_ENABLED, 1'b0);
          end else begin
            push_single(ST_OK, pin_levels[a.pin]);
          end
        end
      endcase
    end
  endtask

  task automatic check_field(input string field, input int expected, input int actual);
    if (expected != actual) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected,
               actual);
    end
  endtask

  // Result checking and prediction at the rising edge.
  always @(posedge clk_i) begin : result_check
    chain_result_t exp_r;
    pin_access_t   acc;
    if (!rst_ni) begin
      in_xfer = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_results.size() == 0) begin
          n_errors++;
          $display("%0t: result with none expected, expected nothing, actual status %0d",
                   $time, status_o);
        end else begin
          exp_r = predicted_results.pop_front();
          check_field("status", exp_r.status, status_o);
          check_field("read_value", exp_r.read_value, read_value_o);
          check_field("shift_bit", exp_r.shift_bit, shift_bit_o);
          check_field("shift_valid", exp_r.shift_valid, shift_valid_o);
          check_field("last", exp_r.last, last_o);
          n_results++;
          if (exp_r.shift_valid) n_chain_bits++;
        end
      end
      in_xfer = in_valid_i && !in_stall_o;
      if (in_xfer) begin
        acc.mode = mode_i;
        acc.pin = pin_index_i;
        acc.fn = func_e'(function_code_i);
        acc.push_pull = push_pull_i;
        acc.level = write_value_i;
        predict_access(acc);
        n_accesses++;
      end
    end
  end

  // Access driver: holds a stalled transfer, otherwise idles or sends the next.
  always @(negedge clk_i) begin : access_driver
    pin_access_t nxt;
    if (rst_ni) begin
      if (in_valid_i && !in_xfer) begin
        // The current transfer is stalled; keep the payload.
      end else if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (pin_accesses.size() != 0 && sender_odds != 0 &&
                   $urandom_range(1, sender_odds) == 1) begin
        in_valid_i <= 1'b0;
        send_gap = $urandom_range(0, 6);
      end else if (pin_accesses.size() != 0) begin
        nxt = pin_accesses.pop_front();
        mode_i <= nxt.mode;
        pin_index_i <= nxt.pin;
        function_code_i <= nxt.fn;
        push_pull_i <= nxt.push_pull;
        write_value_i <= nxt.level;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: one long hold-off when asked, else random stall bursts.
  always @(negedge clk_i) begin
    if (long_hold_req && !long_hold_done) begin
      out_stall_i <= 1'b1;
      hold_cycles++;
      if (hold_cycles >= LONG_HOLD) long_hold_done = 1'b1;
    end else if (recv_gap > 0) begin
      out_stall_i <= 1'b1;
      recv_gap--;
    end else if (receiver_odds != 0 && $urandom_range(1, receiver_odds) == 1) begin
      out_stall_i <= 1'b1;
      recv_gap = $urandom_range(0, 6);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog on cycles without any transfer or register write.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               WATCHDOG_LIMIT, predicted_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic queue_access(input logic [MODE_W-1:0] mode, input int pin, input func_e fn,
                              input logic pp, input logic level);
    pin_accesses.push_back('{mode, PINIDX_W'(pin), fn, pp, level});
  endtask

  // Mostly well-formed accesses on pins inside the chain, some stray ones.
  function automatic pin_access_t random_access(input int pc, input bit few_shifts);
    pin_access_t a;
    int roll;
    int span;
    roll = $urandom_range(0, 99);
    if (few_shifts) begin
      a.mode = (roll < 60) ? MODE_READ : (roll < 90) ? MODE_CFG :
               (roll < 97) ? MODE_WRITE : MODE_UNDEFINED;
    end else begin
      a.mode = (roll < 25) ? MODE_CFG : (roll < 65) ? MODE_WRITE :
               (roll < 95) ? MODE_READ : MODE_UNDEFINED;
    end
    span = (pc > MAX_PINS) ? MAX_PINS : pc;
    if (span > 0 && $urandom_range(0, 9) != 0) begin
      a.pin = PINIDX_W'($urandom_range(0, span - 1));
    end else begin
      a.pin = PINIDX_W'($urandom_range(0, 63));
    end
    roll = $urandom_range(0, 9);
    a.fn = (roll == 0) ? FN_RELEASE : (roll == 1) ? FN_INPUT :
           (roll < 6) ? FN_OUTPUT : FN_KEEP;
    a.push_pull = ($urandom_range(0, 9) != 0);
    a.level = 1'($urandom_range(0, 1));
    return a;
  endfunction

  // Waits until no access is pending and every result has arrived.
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
    end while (pin_accesses.size() != 0 || in_valid_i || predicted_results.size() != 0);
  endtask

  task automatic write_setting(input cfg_idx_e idx, input int value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = CFG_W'(value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_OUT_COUNT) chain_pins = CFG_W'(value);
    else chain_reversed = value[0];
  endtask

  // Settles the block, then writes both registers for the next phase.
  task automatic start_phase(input int pc, input bit rev, input int unsigned odds);
    wait_idle();
    repeat (4) @(negedge clk_i);
    write_setting(CFG_OUT_COUNT, pc);
    write_setting(CFG_REVERSE, int'(rev));
    n_settings++;
    sender_odds = odds;
    receiver_odds = odds;
  endtask

  task automatic queue_random(input int count, input bit few_shifts);
    repeat (count) pin_accesses.push_back(random_access(int'(chain_pins), few_shifts));
  endtask

  // Stimulus sequence.
  initial begin
    int pc;
    pin_levels = '0;
    pin_on = '0;
    chain_pins = OUT_COUNT_RESET;
    chain_reversed = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed accesses at the reset settings: refusals, enables, shifts.
    queue_access(MODE_READ, 0, FN_OUTPUT, 1'b1, 1'b0);
    queue_access(MODE_WRITE, 0, FN_OUTPUT, 1'b1, 1'b1);
    queue_access(MODE_CFG, 0, FN_INPUT, 1'b1, 1'b0);
    queue_access(MODE_CFG, 0, FN_OUTPUT, 1'b0, 1'b0);
    queue_access(MODE_CFG, 0, FN_OUTPUT, 1'b1, 1'b0);
    queue_access(MODE_CFG, 7, FN_KEEP, 1'b1, 1'b0);
    queue_access(MODE_WRITE, 0, FN_OUTPUT, 1'b1, 1'b1);
    queue_access(MODE_WRITE, 7, FN_OUTPUT, 1'b1, 1'b1);
    queue_access(MODE_READ, 0, FN_OUTPUT, 1'b1, 1'b0);
    queue_access(MODE_READ, 7, FN_OUTPUT, 1'b1, 1'b0);
    queue_access(MODE_READ, 8, FN_OUTPUT, 1'b1, 1'b0);
    queue_access(MODE_WRITE, 63, FN_OUTPUT, 1'b1, 1'b1);
    queue_access(MODE_CFG, 32, FN_OUTPUT, 1'b1, 1'b0);
    queue_access(MODE_UNDEFINED, 63, FN_INPUT, 1'b1, 1'b1);
    queue_access(MODE_UNDEFINED, 0, FN_RELEASE, 1'b0, 1'b0);
    queue_access(MODE_CFG, 7, FN_RELEASE, 1'b0, 1'b0);
    queue_access(MODE_READ, 7, FN_OUTPUT, 1'b1, 1'b0);
    queue_access(MODE_WRITE, 7, FN_OUTPUT, 1'b1, 1'b1);
    queue_access(MODE_CFG, 0, FN_RELEASE, 1'b1, 1'b0);
    queue_access(MODE_READ, 0, FN_OUTPUT, 1'b1, 1'b0);
    queue_access(MODE_CFG, 63, FN_RELEASE, 1'b1, 1'b0);

    // Extreme chain settings, the long ones with few accesses.
    start_phase(1, 1'b1, 4);
    queue_random(30, 1'b0);
    start_phase(32, 1'b0, 5);
    queue_random(20, 1'b0);
    start_phase(63, 1'b1, 5);
    queue_random(20, 1'b0);
    start_phase(0, 1'b0, 3);
    queue_random(15, 1'b0);

    // The receiver holds off for a long stretch while accesses keep coming.
    start_phase(5, 1'b0, 4);
    long_hold_req = 1'b1;
    queue_random(40, 1'b1);

    // Short chains with random settings make up most of the run.
    repeat (6) begin
      pc = $urandom_range(2, 12);
      start_phase(pc, 1'($urandom_range(0, 1)), $urandom_range(0, 1) ? 3 : 8);
      queue_random(45, 1'b0);
    end

    // Final stretch without idling on either side.
    pc = $urandom_range(1, 16);
    start_phase(pc, 1'($urandom_range(0, 1)), 0);
    queue_random(40, 1'b0);

    wait_idle();
    repeat (END_CYCLES) @(posedge clk_i);

    $display("Covered %0d pin accesses under %0d chain settings plus reset defaults,",
             n_accesses, n_settings);
    $display("checking %0d results, %0d of them chain bits.", n_results, n_chain_bits);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/sroe_pkg.sv
hdl/shift_register_output_expander_unit.sv
tb/shift_register_output_expander_unit_tb.sv
